>>> rtl/fixed_block_pool_allocator_assert.svh
// assertion macros for the fixed block pool allocator
// used by the top level; expects clk and rst in scope
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
// no dependencies
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 16;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = IDX_W + BYTES_W;
  localparam int DIV_CNT_W  = $clog2(ADDR_W);

  localparam logic [ADDR_W-1:0]  BASE_RESET   = '0;
  localparam logic [BYTES_W-1:0] BYTES_RESET  = BYTES_W'(64);
  localparam logic [CNT_W-1:0]   BLOCKS_RESET = CNT_W'(MAX_BLOCKS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_FULL    = 2'd2,
    STS_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS  = 2'd0,
    REG_BLOCK_BYTES   = 2'd1,
    REG_BLOCKS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [BYTES_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/fbpa_if.sv
// request and response channels of the fixed block pool allocator
// depends on fbpa_pkg
`timescale 1ns / 1ps

interface fbpa_req_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   free_address;

  modport source (output valid, output opcode, output free_address, input ready);
  modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_address;
  logic [IDX_W-1:0]    block_index;
  logic [CNT_W-1:0]    free_blocks;

  modport source (output valid, output status, output block_address, output block_index,
                  output free_blocks, input ready);
  modport sink   (input valid, input status, input block_address, input block_index,
                  input free_blocks, output ready);
endinterface

>>> rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator keeping free block indices on a 256-entry stack
// in a memory with one access per cycle. One transaction in, one transaction out; the block
// takes a new request only when idle. Allocate reads the stack, multiplies the index by
// the block size and adds the base; free runs the 32-step bit-serial divider that turns
// the address offset into a block index; an allocate on an empty pool or a free with
// zero block size goes straight to the result. Initialize writes one stack entry per
// cycle for blocks_in_use entries (clamped to 256); OP_NOP is a no-op. A finished result
// sits in an output register, so the next request is taken while it waits. Configuration
// is written through cfg_we/cfg_index/cfg_data and takes effect at once; the stack is
// rebuilt only by initialize. Out of reset the pool is empty until initialize.
// depends on fbpa_pkg, fbpa_if, fbpa_div and the assertion macro header
`timescale 1ns / 1ps

module fixed_block_pool_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  fbpa_req_if.sink                            req,
  fbpa_rsp_if.source                          rsp
);
  import fbpa_pkg::*;

  `include "fixed_block_pool_allocator_assert.svh"

  logic [ADDR_W-1:0]  base_address;
  logic [BYTES_W-1:0] block_bytes;
  logic [CNT_W-1:0]   blocks_in_use;

  state_t             state, state_next;
  logic [CNT_W-1:0]   top, top_next;
  logic [CNT_W-1:0]   fill_cnt, fill_cnt_next;
  status_t            res_status, res_status_next;
  logic [ADDR_W-1:0]  res_addr, res_addr_next;
  logic [IDX_W-1:0]   res_index, res_index_next;
  logic [PROD_W-1:0]  prod;

  logic               out_valid, out_valid_next;
  logic               out_load;
  status_t            out_status;
  logic [ADDR_W-1:0]  out_addr;
  logic [IDX_W-1:0]   out_index;
  logic [CNT_W-1:0]   out_free;

  logic [IDX_W-1:0]   mem [MAX_BLOCKS];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [IDX_W-1:0]   rd_data;

  logic [CNT_W-1:0]   active_n;
  logic [CNT_W-1:0]   fill_val;
  logic               accept;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= BASE_RESET;
      block_bytes   <= BYTES_RESET;
      blocks_in_use <= BLOCKS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS:  base_address  <= cfg_data[ADDR_W-1:0];
        REG_BLOCK_BYTES:   block_bytes   <= cfg_data[BYTES_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_n  = (blocks_in_use > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : blocks_in_use;
  assign fill_val  = active_n - fill_cnt - 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  fbpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next      = state;
    top_next        = top;
    fill_cnt_next   = fill_cnt;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_index_next  = res_index;
    out_valid_next  = out_valid && !rsp.ready;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = fill_cnt[IDX_W-1:0];
    mem_wdata       = fill_val[IDX_W-1:0];
    mem_re          = 1'b0;
    mem_raddr       = IDX_W'(top - 1'b1);
    div_req.start    = 1'b0;
    div_req.dividend = req.free_address - base_address;
    div_req.divisor  = block_bytes;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_status_next = STS_OK;
          res_addr_next   = '0;
          res_index_next  = '0;
          case (opcode_t'(req.opcode))
            OP_ALLOC: begin
              if (top == '0) begin
                res_status_next = STS_EMPTY;
                state_next      = ST_DONE;
              end else begin
                mem_re     = 1'b1;
                top_next   = top - 1'b1;
                state_next = ST_RD;
              end
            end
            OP_FREE: begin
              if (block_bytes == '0) begin
                res_status_next = STS_OUTSIDE;
                state_next      = ST_DONE;
              end else begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
              end
            end
            OP_INIT: begin
              fill_cnt_next = '0;
              if (active_n == '0) begin
                top_next   = '0;
                state_next = ST_DONE;
              end else begin
                state_next = ST_FILL;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we        = 1'b1;
        fill_cnt_next = fill_cnt + 1'b1;
        if (fill_cnt == active_n - 1'b1) begin
          top_next   = active_n;
          state_next = ST_DONE;
        end
      end
      ST_RD: begin
        res_index_next = rd_data;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        res_addr_next = base_address + ADDR_W'(prod);
        state_next    = ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
          if (div_rsp.quotient >= ADDR_W'(active_n)) begin
            res_status_next = STS_OUTSIDE;
          end else if (top >= active_n) begin
            res_status_next = STS_FULL;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = top[IDX_W-1:0];
            mem_wdata      = div_rsp.quotient[IDX_W-1:0];
            top_next       = top + 1'b1;
            res_index_next = div_rsp.quotient[IDX_W-1:0];
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      top       <= '0;
      fill_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      top       <= top_next;
      fill_cnt  <= fill_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    res_index  <= res_index_next;
    if (state == ST_RD) begin
      prod <= rd_data * block_bytes;
    end
    if (out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_index  <= res_index;
      out_free   <= top;
    end
  end

  // free index stack
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.block_address = out_addr;
  assign rsp.block_index   = out_index;
  assign rsp.free_blocks   = out_free;

  `FBPA_ASSERT_NOW(a_top_bound, 1'b1, top <= CNT_W'(MAX_BLOCKS), "stack top beyond capacity")
  `FBPA_ASSERT_NOW(a_empty_count, rsp.valid && rsp.status == STS_EMPTY,
    rsp.free_blocks == '0, "empty status with free blocks left")
  `FBPA_ASSERT_NEXT(a_alloc_pop, accept && req.opcode == OP_ALLOC && top != '0,
    top == $past(top) - 1'b1, "allocate did not pop one entry")
  `FBPA_ASSERT_NOW(a_div_owner, div_rsp.done, state == ST_DIV, "divider done outside free")

endmodule

>>> rtl/fbpa_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_div (
  input  logic               clk,
  input  logic               rst,
  input  fbpa_pkg::div_req_t req,
  output fbpa_pkg::div_rsp_t rsp
);
  import fbpa_pkg::*;

  logic                 running;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BYTES_W-1:0]   rem;
  logic [BYTES_W-1:0]   divisor;
  logic [ADDR_W-1:0]    quo;
  logic [BYTES_W:0]     shifted;
  logic [BYTES_W:0]     trial;
  logic                 fits;

  assign shifted = {rem, quo[ADDR_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == DIV_CNT_W'(ADDR_W - 1));
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(ADDR_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      rem <= fits ? trial[BYTES_W-1:0] : shifted[BYTES_W-1:0];
      quo <= {quo[ADDR_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
